// ----- sv/deq_pkg.sv -----
package deq_pkg;

    localparam int WORD_W        = 32;
    localparam int MAX_DEPTH     = 64;
    localparam int DEFAULT_DEPTH = 64;
    // Wide enough to hold a fill count of MAX_DEPTH
    localparam int CNT_W         = $clog2(MAX_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_REAR,
        CELL_SHIFT_FRONT,
        CELL_LOAD_TAIL,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

// ----- sv/deq_cell.sv -----
module deq_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  deq_pkg::cell_ctrl_t        ctrl,
    input  logic [deq_pkg::WORD_W-1:0] value,
    input  logic [deq_pkg::WORD_W-1:0] left_data,
    input  logic [deq_pkg::WORD_W-1:0] right_data,
    input  logic [deq_pkg::WORD_W-1:0] wrap_data,
    output logic [deq_pkg::WORD_W-1:0] data
);
    import deq_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [CNT_W-1:0]  tail;

    assign tail = ctrl.count - 1'b1;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:        data_next = data_reg;
            CELL_SHIFT_REAR:  data_next = (IDX == 0) ? value : left_data;
            CELL_SHIFT_FRONT: data_next = right_data;
            CELL_LOAD_TAIL:
            begin
                if (IDX_C == ctrl.count)
                    data_next = value;
            end
            CELL_ROTATE:
            begin
                // the tail cell takes the old front, the rest move one toward the front
                if (IDX_C == tail)
                    data_next = wrap_data;
                else if (IDX_C < tail)
                    data_next = right_data;
            end
            default:          data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit words.
// Input channel s_*: one item per handshake, operation in s_tuser, word in s_tdata.
// Output channel m_*: result word in m_tdata, status in m_tuser, m_tlast on the
// final result of an item. Results sit in a single output register.
// Storage is a row of DEPTH cells, cell 0 the front, words packed toward it.
// Steps per item, n being the fill count:
//   push front, push rear, pop front: done in the accept cycle, result registered.
//   pop rear: the occupied cells rotate n - 1 times until the
//   rear word reaches cell 0, then a pop from the front removes it.
//   list: n results, one a cycle while the output is free, each a rotation
//   of the occupied cells so that after n rotations the order is restored.
// Errors (full, empty) give a single result marked last; unused op codes are dropped.
// A new item is taken only when the block is idle and the output register
// is free or being emptied. When m_tready is low, results hold, a list waits,
// and a pop rear finishes its rotations and then waits to pop.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// result; cell contents are not cleared.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [deq_pkg::WORD_W-1:0] s_tdata,   // [31:0] value
    input  logic [2:0]                 s_tuser,   // [2:0] op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [deq_pkg::WORD_W-1:0] m_tdata,   // [31:0] word
    output logic [1:0]                 m_tuser,   // [1:0] status
    output logic                       m_tlast
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_LIST
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             m_tvalid_reg;
    logic [WORD_W-1:0] m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;

    logic              slot_free;
    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  tail;
    logic              emit;
    logic [WORD_W-1:0] emit_word;
    status_t           emit_status;
    logic              emit_last;
    cell_ctrl_t        ctrl;

    logic [WORD_W-1:0] cell_data [DEPTH];

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign tail      = count_reg - 1'b1;

    // Chain of cells: each takes its neighbors, the front word wraps to the tail
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        deq_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (s_tdata),
            .left_data  ((i == 0) ? s_tdata : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .wrap_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        ctrl.cmd    = CELL_HOLD;
        ctrl.count  = count_reg;
        emit        = 1'b0;
        emit_word   = '0;
        emit_status = ST_OK;
        emit_last   = 1'b1;
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            emit = 1'b1;
                            if (full)
                                emit_status = ST_FULL;
                            else
                            begin
                                emit_word  = s_tdata;
                                ctrl.cmd   = (s_tuser == OP_PUSH_FRONT) ? CELL_SHIFT_REAR
                                                                        : CELL_LOAD_TAIL;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            emit = 1'b1;
                            if (empty)
                                emit_status = ST_EMPTY;
                            else
                            begin
                                emit_word  = cell_data[0];
                                ctrl.cmd   = CELL_SHIFT_FRONT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_ROT;
                                step_next  = '0;
                            end
                        end
                        OP_LIST:
                        begin
                            emit = 1'b1;
                            if (empty)
                                emit_status = ST_EMPTY;
                            else
                            begin
                                emit_word = cell_data[0];
                                emit_last = (count_reg == CNT_W'(1));
                                ctrl.cmd  = CELL_ROTATE;
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = S_LIST;
                                    step_next  = CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // unused op codes: drop the item
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                if (step_reg == tail)
                begin
                    // rear word now sits at the front: pop it
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        emit_word  = cell_data[0];
                        ctrl.cmd   = CELL_SHIFT_FRONT;
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.cmd  = CELL_ROTATE;
                    step_next = step_reg + 1'b1;
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_word = cell_data[0];
                    emit_last = (step_reg == tail);
                    ctrl.cmd  = CELL_ROTATE;
                    step_next = step_reg + 1'b1;
                    if (step_reg == tail)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output register: load a new result, clear valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= emit_word;
                m_tuser_reg  <= emit_status;
                m_tlast_reg  <= emit_last;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count exceeds depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_tuser == OP_PUSH_FRONT || s_tuser == OP_PUSH_REAR) && !full
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
        else $error("error result not marked last");

    a_list_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |=> count_reg == $past(count_reg))
        else $error("fill count changed during list");
`endif

endmodule
